// ===== rtl/core/assert_macros.svh =====
// assertion helpers, sampled on clk and disabled while arst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

`define ASSERT_IMPLY(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

`define ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// ===== rtl/core/lap3d_pkg.sv =====
package lap3d_pkg;

	localparam int CFG_WIDTH_BITS  = 7;
	localparam int CFG_HEIGHT_BITS = 7;
	localparam int CFG_DEPTH_BITS  = 11;
	localparam int CFG_IDX_W       = 2;
	localparam int CFG_DATA_W      = 11;
	localparam int RESULT_W        = 20;

	localparam logic [CFG_WIDTH_BITS-1:0]  CFG_WIDTH_RESET  = 7'd64;
	localparam logic [CFG_HEIGHT_BITS-1:0] CFG_HEIGHT_RESET = 7'd64;
	localparam logic [CFG_DEPTH_BITS-1:0]  CFG_DEPTH_RESET  = 11'd1024;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WIDTH  = 2'd0,
		REG_HEIGHT = 2'd1,
		REG_DEPTH  = 2'd2
	} lap3d_reg_t;

	localparam logic ACT_PUSH  = 1'b0;
	localparam logic ACT_DRAIN = 1'b1;

	typedef struct packed {
		logic emit;
		logic last;
		logic has_xm;
		logic has_xp;
		logic has_ym;
		logic has_yp;
		logic has_zm;
		logic has_zp;
	} lap3d_flags_t;

endpackage

// ===== rtl/core/lap3d_front.sv =====
module lap3d_front #(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64,
	parameter int MAX_DEPTH  = 1024
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               restart,
	input  logic                               accept,
	input  logic                               action,
	input  logic [$clog2(MAX_WIDTH + 1)-1:0]   w_eff,
	input  logic [$clog2(MAX_HEIGHT + 1)-1:0]  h_eff,
	input  logic [$clog2(MAX_DEPTH + 1)-1:0]   d_eff,
	output logic                               enq,
	output lap3d_pkg::lap3d_flags_t            flags,
	output logic                               done
);
	import lap3d_pkg::*;

	localparam int WB = $clog2(MAX_WIDTH + 1);
	localparam int HB = $clog2(MAX_HEIGHT + 1);
	localparam int DB = $clog2(MAX_DEPTH + 1);
	localparam int CX = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int CY = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int CZ = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

	logic [CX-1:0] in_col_q, out_col_q;
	logic [CY-1:0] in_row_q, out_row_q;
	logic [CZ-1:0] in_plane_q, out_plane_q;
	logic          done_q;

	logic is_push, is_drain, emit;
	logic in_x_end, in_y_end, in_z_end;
	logic out_x_end, out_y_end, out_z_end;

	always_comb begin
		is_push   = accept && (action == ACT_PUSH) && !done_q;
		is_drain  = accept && (action == ACT_DRAIN) && done_q;
		emit      = is_drain || (is_push && (in_plane_q != '0));
		in_x_end  = (WB'(in_col_q) + WB'(1)) == w_eff;
		in_y_end  = (HB'(in_row_q) + HB'(1)) == h_eff;
		in_z_end  = (DB'(in_plane_q) + DB'(1)) == d_eff;
		out_x_end = (WB'(out_col_q) + WB'(1)) == w_eff;
		out_y_end = (HB'(out_row_q) + HB'(1)) == h_eff;
		out_z_end = (DB'(out_plane_q) + DB'(1)) == d_eff;

		flags.emit   = emit;
		flags.last   = emit && out_x_end && out_y_end && out_z_end;
		flags.has_xm = out_col_q != '0;
		flags.has_xp = !out_x_end;
		flags.has_ym = out_row_q != '0;
		flags.has_yp = !out_y_end;
		flags.has_zm = out_plane_q != '0;
		flags.has_zp = !out_z_end;
	end

	assign enq  = is_push || is_drain;
	assign done = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q    <= '0;
			in_row_q    <= '0;
			in_plane_q  <= '0;
			out_col_q   <= '0;
			out_row_q   <= '0;
			out_plane_q <= '0;
			done_q      <= 1'b0;
		end else if (restart || flags.last) begin
			in_col_q    <= '0;
			in_row_q    <= '0;
			in_plane_q  <= '0;
			out_col_q   <= '0;
			out_row_q   <= '0;
			out_plane_q <= '0;
			done_q      <= 1'b0;
		end else begin
			if (is_push) begin
				if (in_x_end) begin
					in_col_q <= '0;
					if (in_y_end) begin
						in_row_q <= '0;
						if (in_z_end) begin
							in_plane_q <= '0;
							done_q     <= 1'b1;
						end else begin
							in_plane_q <= in_plane_q + CZ'(1);
						end
					end else begin
						in_row_q <= in_row_q + CY'(1);
					end
				end else begin
					in_col_q <= in_col_q + CX'(1);
				end
			end
			if (emit) begin
				if (out_x_end) begin
					out_col_q <= '0;
					if (out_y_end) begin
						out_row_q   <= '0;
						out_plane_q <= out_plane_q + CZ'(1);
					end else begin
						out_row_q <= out_row_q + CY'(1);
					end
				end else begin
					out_col_q <= out_col_q + CX'(1);
				end
			end
		end
	end

endmodule

// ===== rtl/core/lap3d_fifo.sv =====
module lap3d_fifo #(
	parameter int DATA_W = 24,
	parameter int DEPTH  = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [DATA_W-1:0] din,
	input  logic              pop,
	output logic [DATA_W-1:0] dout,
	output logic              empty,
	output logic              full
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);

	logic [DATA_W-1:0] slot_q [DEPTH];
	logic [AW-1:0]     wr_q, rd_q;
	logic [NW-1:0]     cnt_q;

	assign empty = cnt_q == '0;
	assign full  = cnt_q == NW'(DEPTH);
	assign dout  = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
			end
			unique case ({push, pop})
				2'b10: begin
					cnt_q <= cnt_q + NW'(1);
				end
				2'b01: begin
					cnt_q <= cnt_q - NW'(1);
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// ===== rtl/core/lap3d_delay.sv =====
module lap3d_delay #(
	parameter int DEPTH  = 1,
	parameter int LEN_W  = 1,
	parameter int DATA_W = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              restart,
	input  logic              shift,
	input  logic [LEN_W-1:0]  len,
	input  logic [DATA_W-1:0] din,
	output logic [DATA_W-1:0] dout
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = (AW + 1 > LEN_W) ? AW + 1 : LEN_W;

	logic [DATA_W-1:0] mem [DEPTH];
	logic [AW-1:0]     ptr_q;
	logic [DATA_W-1:0] rd_q, byp_q;
	logic              wrap;

	assign wrap = (CW'(ptr_q) + CW'(1)) >= CW'(len);
	assign dout = (len == '0) ? byp_q : rd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
		end else if (restart) begin
			ptr_q <= '0;
		end else if (shift) begin
			ptr_q <= wrap ? '0 : ptr_q + AW'(1);
		end
	end

	// read-first ring: the old entry leaves as the new one goes in
	always_ff @(posedge clk) begin
		if (shift) begin
			rd_q       <= mem[ptr_q];
			mem[ptr_q] <= din;
			byp_q      <= din;
		end
	end

endmodule

// ===== rtl/core/lap3d_back.sv =====
module lap3d_back #(
	parameter int MAX_WIDTH   = 64,
	parameter int MAX_HEIGHT  = 64,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      restart,
	input  logic [$clog2(MAX_WIDTH * MAX_HEIGHT + 1)-1:0] plane,
	input  logic [$clog2(MAX_WIDTH + 1)-1:0]          w_eff,
	input  logic                                      q_valid,
	input  lap3d_pkg::lap3d_flags_t                   q_flags,
	input  logic [SAMPLE_BITS-1:0]                    q_sample,
	output logic                                      q_pop,
	input  logic                                      res_stall,
	output logic                                      res_valid,
	output logic signed [lap3d_pkg::RESULT_W-1:0]     result_value,
	output logic                                      is_last
);
	import lap3d_pkg::*;

	localparam int PLANE_MAX = MAX_WIDTH * MAX_HEIGHT;
	localparam int PB        = $clog2(PLANE_MAX + 1);
	localparam int WB        = $clog2(MAX_WIDTH + 1);
	localparam int DEPTH_P   = (PLANE_MAX > 1) ? PLANE_MAX - 1 : 1;
	localparam int DEPTH_W   = (PLANE_MAX > MAX_WIDTH) ? PLANE_MAX - MAX_WIDTH : 1;
	localparam int DEPTH_M   = (MAX_WIDTH > 1) ? MAX_WIDTH - 1 : 1;
	localparam int DW        = SAMPLE_BITS + 1;
	localparam int SW        = SAMPLE_BITS + 2;
	localparam int TW        = SAMPLE_BITS + 4;

	function automatic logic signed [DW-1:0] face(
		input logic                          has,
		input logic signed [SAMPLE_BITS-1:0] c,
		input logic signed [SAMPLE_BITS-1:0] n
	);
		if (!has) begin
			return '0;
		end
		return DW'(c) - DW'(n);
	endfunction

	logic          adv;
	logic [PB-1:0] len_p, len_w;
	logic [WB-1:0] len_m;

	logic [SAMPLE_BITS-1:0] tap_xp, tap_yp, tap_ym, tap_zm;
	logic [SAMPLE_BITS-1:0] pp_q, p_q, pm1_q;

	logic         v_s1;
	lap3d_flags_t fl_s1;
	logic         v_s2, last_s2;
	logic signed [SW-1:0] sum_x_s2, sum_y_s2, sum_z_s2;

	logic                       res_valid_q, last_q;
	logic signed [RESULT_W-1:0] result_q;

	assign adv   = !res_valid_q || !res_stall;
	assign q_pop = adv && q_valid;

	assign len_p = plane - PB'(1);
	assign len_w = plane - PB'(w_eff);
	assign len_m = w_eff - WB'(1);

	lap3d_delay #(.DEPTH(DEPTH_P), .LEN_W(PB), .DATA_W(SAMPLE_BITS)) u_line_xp (
		.clk(clk), .arst_n(arst_n), .restart(restart), .shift(q_pop),
		.len(len_p), .din(q_sample), .dout(tap_xp)
	);

	lap3d_delay #(.DEPTH(DEPTH_W), .LEN_W(PB), .DATA_W(SAMPLE_BITS)) u_line_yp (
		.clk(clk), .arst_n(arst_n), .restart(restart), .shift(q_pop),
		.len(len_w), .din(q_sample), .dout(tap_yp)
	);

	lap3d_delay #(.DEPTH(DEPTH_M), .LEN_W(WB), .DATA_W(SAMPLE_BITS)) u_line_ym (
		.clk(clk), .arst_n(arst_n), .restart(restart), .shift(q_pop),
		.len(len_m), .din(p_q), .dout(tap_ym)
	);

	lap3d_delay #(.DEPTH(DEPTH_P), .LEN_W(PB), .DATA_W(SAMPLE_BITS)) u_line_zm (
		.clk(clk), .arst_n(arst_n), .restart(restart), .shift(q_pop),
		.len(len_p), .din(p_q), .dout(tap_zm)
	);

	always_ff @(posedge clk) begin
		if (q_pop) begin
			pp_q  <= q_sample;
			p_q   <= tap_xp;
			pm1_q <= p_q;
			fl_s1 <= q_flags;
		end
		if (adv) begin
			last_s2  <= fl_s1.last;
			sum_x_s2 <= SW'(face(fl_s1.has_xm, pm1_q, p_q) * -1)
				+ SW'(face(fl_s1.has_xp, p_q, tap_xp));
			sum_y_s2 <= SW'(face(fl_s1.has_ym, p_q, tap_ym))
				+ SW'(face(fl_s1.has_yp, p_q, tap_yp));
			sum_z_s2 <= SW'(face(fl_s1.has_zm, p_q, tap_zm))
				+ SW'(face(fl_s1.has_zp, p_q, pp_q));
			result_q <= RESULT_W'(TW'(sum_x_s2) + TW'(sum_y_s2) + TW'(sum_z_s2));
			last_q   <= last_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			res_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= q_pop;
			v_s2        <= v_s1 && fl_s1.emit;
			res_valid_q <= v_s2;
		end
	end

	assign res_valid    = res_valid_q;
	assign result_value = result_q;
	assign is_last      = last_q;

endmodule

// ===== rtl/core/laplacian_3d_stencil.sv =====
// channel  side  handshake              payload
// item     in    item_valid/item_stall  action, sample
// result   out   res_valid/res_stall    result_value, is_last
// cfg      in    cfg_valid/cfg_ready    cfg_index, cfg_data
//
// one request accepted per clock while item_stall is low; a result is registered in
// the queue slot, delay-line read register and two adder stages
// async reset clears counters, pointers and valid bits; history lines are not cleared
// res_stall freezes the back pipeline, the 4-entry queue keeps taking requests
// until full and item_stall rises; a width, height or depth write restarts the volume
`include "assert_macros.svh"

module laplacian_3d_stencil #(
	parameter int MAX_WIDTH   = 64,
	parameter int MAX_HEIGHT  = 64,
	parameter int MAX_DEPTH   = 1024,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  item_valid,
	output logic                                  item_stall,
	input  logic                                  action,
	input  logic signed [SAMPLE_BITS-1:0]         sample,
	output logic                                  res_valid,
	input  logic                                  res_stall,
	output logic signed [lap3d_pkg::RESULT_W-1:0] result_value,
	output logic                                  is_last,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [lap3d_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [lap3d_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import lap3d_pkg::*;

	localparam int WB          = $clog2(MAX_WIDTH + 1);
	localparam int HB          = $clog2(MAX_HEIGHT + 1);
	localparam int DB          = $clog2(MAX_DEPTH + 1);
	localparam int PB          = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
	localparam int QUEUE_DEPTH = 4;
	localparam int FLAGS_W     = $bits(lap3d_flags_t);
	localparam int ENTRY_W     = FLAGS_W + SAMPLE_BITS;

	function automatic logic [WB-1:0] clamp_w(input logic [CFG_WIDTH_BITS-1:0] v);
		if (v == '0) begin
			return WB'(1);
		end
		if (32'(v) > MAX_WIDTH) begin
			return WB'(MAX_WIDTH);
		end
		return WB'(v);
	endfunction

	function automatic logic [HB-1:0] clamp_h(input logic [CFG_HEIGHT_BITS-1:0] v);
		if (v == '0) begin
			return HB'(1);
		end
		if (32'(v) > MAX_HEIGHT) begin
			return HB'(MAX_HEIGHT);
		end
		return HB'(v);
	endfunction

	function automatic logic [DB-1:0] clamp_d(input logic [CFG_DEPTH_BITS-1:0] v);
		if (v == '0) begin
			return DB'(1);
		end
		if (32'(v) > MAX_DEPTH) begin
			return DB'(MAX_DEPTH);
		end
		return DB'(v);
	endfunction

	logic [CFG_WIDTH_BITS-1:0]  width_q;
	logic [CFG_HEIGHT_BITS-1:0] height_q;
	logic [CFG_DEPTH_BITS-1:0]  depth_q;
	logic [PB-1:0]              plane_q;
	logic [WB-1:0]              w_eff;
	logic [HB-1:0]              h_eff;
	logic [DB-1:0]              d_eff;
	logic                       cfg_wr, cfg_restart;

	logic               accept, in_done;
	logic               q_push, q_empty, q_full, q_pop;
	lap3d_flags_t       push_flags, head_flags;
	logic [ENTRY_W-1:0] head_entry;

	assign cfg_ready   = 1'b1;
	assign cfg_wr      = cfg_valid && cfg_ready;
	assign cfg_restart = cfg_wr && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT
		|| cfg_index == REG_DEPTH);

	assign w_eff = clamp_w(width_q);
	assign h_eff = clamp_h(height_q);
	assign d_eff = clamp_d(depth_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= CFG_WIDTH_RESET;
			height_q <= CFG_HEIGHT_RESET;
			depth_q  <= CFG_DEPTH_RESET;
			plane_q  <= PB'(clamp_w(CFG_WIDTH_RESET)) * PB'(clamp_h(CFG_HEIGHT_RESET));
		end else begin
			plane_q <= PB'(w_eff) * PB'(h_eff);
			if (cfg_wr) begin
				unique case (cfg_index)
					REG_WIDTH: begin
						width_q <= cfg_data[CFG_WIDTH_BITS-1:0];
					end
					REG_HEIGHT: begin
						height_q <= cfg_data[CFG_HEIGHT_BITS-1:0];
					end
					REG_DEPTH: begin
						depth_q <= cfg_data[CFG_DEPTH_BITS-1:0];
					end
					default: begin
					end
				endcase
			end
		end
	end

	assign item_stall = q_full;
	assign accept     = item_valid && !item_stall;

	lap3d_front #(
		.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .MAX_DEPTH(MAX_DEPTH)
	) u_front (
		.clk(clk), .arst_n(arst_n), .restart(cfg_restart), .accept(accept),
		.action(action), .w_eff(w_eff), .h_eff(h_eff), .d_eff(d_eff),
		.enq(q_push), .flags(push_flags), .done(in_done)
	);

	lap3d_fifo #(.DATA_W(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_queue (
		.clk(clk), .arst_n(arst_n), .push(q_push), .din({push_flags, sample}),
		.pop(q_pop), .dout(head_entry), .empty(q_empty), .full(q_full)
	);

	assign head_flags = lap3d_flags_t'(head_entry[ENTRY_W-1:SAMPLE_BITS]);

	lap3d_back #(
		.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .SAMPLE_BITS(SAMPLE_BITS)
	) u_back (
		.clk(clk), .arst_n(arst_n), .restart(cfg_restart), .plane(plane_q),
		.w_eff(w_eff), .q_valid(!q_empty), .q_flags(head_flags),
		.q_sample(head_entry[SAMPLE_BITS-1:0]), .q_pop(q_pop),
		.res_stall(res_stall), .res_valid(res_valid),
		.result_value(result_value), .is_last(is_last)
	);

	`ASSERT_ALWAYS(a_queue_no_overflow, !(q_push && q_full), "request pushed into a full queue")
	`ASSERT_IMPLY(a_last_from_drain, q_push && push_flags.last, action == ACT_DRAIN, "final voxel not from a drain")
	`ASSERT_NEXT(a_restart_after_last, q_push && push_flags.last, !in_done, "stream did not restart after final voxel")

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import lap3d_pkg::*;

	localparam int MAX_W = 64;
	localparam int MAX_H = 64;
	localparam int MAX_D = 1024;
	localparam int HIST_DEPTH = 2 * MAX_W * MAX_H + 1;
	localparam int SETTLE_CYCLES = 8;
	localparam int LONG_HOLD = 64;
	localparam int REQ_GOAL = 570;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	typedef struct packed {
		logic signed [RESULT_W-1:0] value;
		logic last;
	} lap_result_t;

	typedef enum logic [1:0] {
		STEP_REG,
		STEP_CHECKED,
		STEP_SILENT,
		STEP_KNOWN
	} step_kind_t;

	typedef struct packed {
		step_kind_t kind;
		logic [CFG_IDX_W-1:0] idx;
		logic [CFG_DATA_W-1:0] data;
		logic act;
		logic signed [15:0] smp;
		logic signed [RESULT_W-1:0] value;
		logic last;
	} plan_row_t;

	localparam int PLAN_LEN = 33;
	localparam plan_row_t PLAN [PLAN_LEN] = '{
		// reset shape: one plane is 4096 voxels, nothing comes out yet
		'{STEP_SILENT, REG_WIDTH, 11'd0, ACT_PUSH, 16'sh7fff, 20'sd0, 1'b0},
		'{STEP_SILENT, REG_WIDTH, 11'd0, ACT_DRAIN, 16'sh0000, 20'sd0, 1'b0},
		// zero registers act as one: a 1x1x3 column
		'{STEP_REG, REG_WIDTH, 11'd0, ACT_PUSH, 16'sh0000, 20'sd0, 1'b0},
		'{STEP_REG, REG_HEIGHT, 11'd0, ACT_PUSH, 16'sh0000, 20'sd0, 1'b0},
		'{STEP_REG, REG_DEPTH, 11'd3, ACT_PUSH, 16'sh0000, 20'sd0, 1'b0},
		'{STEP_SILENT, REG_WIDTH, 11'd0, ACT_PUSH, 16'sh8000, 20'sd0, 1'b0},
		'{STEP_KNOWN, REG_WIDTH, 11'd0, ACT_PUSH, 16'sh7fff, -20'sd65535, 1'b0},
		'{STEP_KNOWN, REG_WIDTH, 11'd0, ACT_PUSH, 16'sh8000, 20'sd131070, 1'b0},
		// volume full: push dropped, drain flushes the last voxel
		'{STEP_SILENT, REG_WIDTH, 11'd0, ACT_PUSH, 16'sh0005, 20'sd0, 1'b0},
		'{STEP_KNOWN, REG_WIDTH, 11'd0, ACT_DRAIN, 16'sh0000, -20'sd65535, 1'b1},
		'{STEP_SILENT, REG_WIDTH, 11'd0, ACT_DRAIN, 16'sh0000, 20'sd0, 1'b0},
		// oversized registers clamp to the maximum
		'{STEP_REG, REG_WIDTH, 11'h7ff, ACT_PUSH, 16'sh0000, 20'sd0, 1'b0},
		'{STEP_REG, REG_HEIGHT, 11'd1, ACT_PUSH, 16'sh0000, 20'sd0, 1'b0},
		'{STEP_REG, REG_DEPTH, 11'h7ff, ACT_PUSH, 16'sh0000, 20'sd0, 1'b0},
		'{STEP_SILENT, REG_WIDTH, 11'd0, ACT_PUSH, 16'sh5555, 20'sd0, 1'b0},
		'{STEP_SILENT, REG_WIDTH, 11'd0, ACT_PUSH, 16'shaaaa, 20'sd0, 1'b0},
		'{STEP_REG, REG_SPARE, 11'h2aa, ACT_PUSH, 16'sh0000, 20'sd0, 1'b0},
		'{STEP_SILENT, REG_WIDTH, 11'd0, ACT_PUSH, 16'sh0000, 20'sd0, 1'b0},
		// 2x2x2 cube
		'{STEP_REG, REG_WIDTH, 11'd2, ACT_PUSH, 16'sh0000, 20'sd0, 1'b0},
		'{STEP_REG, REG_HEIGHT, 11'd2, ACT_PUSH, 16'sh0000, 20'sd0, 1'b0},
		'{STEP_REG, REG_DEPTH, 11'd2, ACT_PUSH, 16'sh0000, 20'sd0, 1'b0},
		'{STEP_CHECKED, REG_WIDTH, 11'd0, ACT_PUSH, 16'sh7fff, 20'sd0, 1'b0},
		'{STEP_CHECKED, REG_WIDTH, 11'd0, ACT_PUSH, 16'sh8000, 20'sd0, 1'b0},
		'{STEP_CHECKED, REG_WIDTH, 11'd0, ACT_PUSH, 16'shffff, 20'sd0, 1'b0},
		'{STEP_CHECKED, REG_WIDTH, 11'd0, ACT_PUSH, 16'sh0000, 20'sd0, 1'b0},
		'{STEP_CHECKED, REG_WIDTH, 11'd0, ACT_PUSH, 16'sh0001, 20'sd0, 1'b0},
		'{STEP_CHECKED, REG_WIDTH, 11'd0, ACT_PUSH, 16'sh7fff, 20'sd0, 1'b0},
		'{STEP_CHECKED, REG_WIDTH, 11'd0, ACT_PUSH, 16'sh8000, 20'sd0, 1'b0},
		'{STEP_CHECKED, REG_WIDTH, 11'd0, ACT_PUSH, 16'sh1234, 20'sd0, 1'b0},
		'{STEP_CHECKED, REG_WIDTH, 11'd0, ACT_DRAIN, 16'sh0000, 20'sd0, 1'b0},
		'{STEP_CHECKED, REG_WIDTH, 11'd0, ACT_DRAIN, 16'shffff, 20'sd0, 1'b0},
		'{STEP_CHECKED, REG_WIDTH, 11'd0, ACT_DRAIN, 16'sh0000, 20'sd0, 1'b0},
		'{STEP_CHECKED, REG_WIDTH, 11'd0, ACT_DRAIN, 16'sh0000, 20'sd0, 1'b0}
	};

	logic clk;
	logic arst_n;
	logic item_valid;
	logic item_stall;
	logic action;
	logic signed [15:0] sample;
	logic res_valid;
	logic res_stall;
	logic signed [RESULT_W-1:0] result_value;
	logic is_last;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// predictor state
	logic signed [15:0] voxel_hist [HIST_DEPTH];
	logic [CFG_WIDTH_BITS-1:0] cols_reg = CFG_WIDTH_RESET;
	logic [CFG_HEIGHT_BITS-1:0] rows_reg = CFG_HEIGHT_RESET;
	logic [CFG_DEPTH_BITS-1:0] frames_reg = CFG_DEPTH_RESET;
	int unsigned voxels_taken = 0;
	int unsigned due_col = 0;
	int unsigned due_row = 0;
	int unsigned due_frame = 0;

	lap_result_t pending_laplacians [$];
	int reqs_effective = 0;
	int results_seen = 0;
	int mismatches = 0;
	bit quiet = 0;
	bit calm = 0;

	laplacian_3d_stencil uut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.action(action),
		.sample(sample),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.result_value(result_value),
		.is_last(is_last),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic void restart_volume();
		voxels_taken = 0;
		due_col = 0;
		due_row = 0;
		due_frame = 0;
	endfunction

	function automatic void volume_shape(output int unsigned w, output int unsigned h,
			output int unsigned d, output int unsigned plane, output int unsigned total);
		w = (cols_reg == 0) ? 1 : (cols_reg > MAX_W) ? MAX_W : cols_reg;
		h = (rows_reg == 0) ? 1 : (rows_reg > MAX_H) ? MAX_H : rows_reg;
		d = (frames_reg == 0) ? 1 : (frames_reg > MAX_D) ? MAX_D : frames_reg;
		plane = w * h;
		total = plane * d;
	endfunction

	function automatic void laplacian_step(input logic act, input logic signed [15:0] smp,
			output bit gives, output lap_result_t r);
		int unsigned w, h, d, plane, total, p;
		int centre, nbr_sum, nbrs, acc;
		gives = 1'b0;
		r = '0;
		volume_shape(w, h, d, plane, total);
		if (act == ACT_PUSH) begin
			if (voxels_taken >= total)
				return;
			voxel_hist[voxels_taken % HIST_DEPTH] = smp;
			voxels_taken++;
			reqs_effective++;
			if (voxels_taken - 1 < plane)
				return;
		end else begin
			if (voxels_taken < total)
				return;
			reqs_effective++;
		end
		p = due_frame * plane + due_row * w + due_col;
		centre = voxel_hist[p % HIST_DEPTH];
		nbr_sum = 0;
		nbrs = 0;
		if (due_frame > 0) begin
			nbr_sum += voxel_hist[(p - plane) % HIST_DEPTH];
			nbrs++;
		end
		if (due_frame + 1 < d) begin
			nbr_sum += voxel_hist[(p + plane) % HIST_DEPTH];
			nbrs++;
		end
		if (due_row > 0) begin
			nbr_sum += voxel_hist[(p - w) % HIST_DEPTH];
			nbrs++;
		end
		if (due_row + 1 < h) begin
			nbr_sum += voxel_hist[(p + w) % HIST_DEPTH];
			nbrs++;
		end
		if (due_col > 0) begin
			nbr_sum += voxel_hist[(p - 1) % HIST_DEPTH];
			nbrs++;
		end
		if (due_col + 1 < w) begin
			nbr_sum += voxel_hist[(p + 1) % HIST_DEPTH];
			nbrs++;
		end
		acc = nbrs * centre - nbr_sum;
		gives = 1'b1;
		r.value = acc[RESULT_W-1:0];
		r.last = (due_col + 1 == w) && (due_row + 1 == h) && (due_frame + 1 == d);
		if (r.last) begin
			restart_volume();
		end else begin
			due_col++;
			if (due_col >= w) begin
				due_col = 0;
				due_row++;
				if (due_row >= h) begin
					due_row = 0;
					due_frame++;
				end
			end
		end
	endfunction

	function automatic logic signed [15:0] rand_voxel();
		case ($urandom_range(0, 11))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2: return 16'sh0000;
			3: return 16'shffff;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic settle();
		item_valid <= 1'b0;
		while (pending_laplacians.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		settle();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			REG_WIDTH: cols_reg = data[CFG_WIDTH_BITS-1:0];
			REG_HEIGHT: rows_reg = data[CFG_HEIGHT_BITS-1:0];
			REG_DEPTH: frames_reg = data[CFG_DEPTH_BITS-1:0];
			default: ;
		endcase
		if (idx != REG_SPARE)
			restart_volume();
	endtask

	task automatic issue(input logic act, input logic signed [15:0] smp, input step_kind_t kind,
			input logic signed [RESULT_W-1:0] known_val, input logic known_last);
		lap_result_t r;
		bit gives;
		quiet = quiet || (reqs_effective + 80 >= REQ_GOAL);
		if (!quiet && !calm && $urandom_range(0, 3) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		item_valid <= 1'b1;
		action <= act;
		sample <= smp;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		laplacian_step(act, smp, gives, r);
		if (kind == STEP_KNOWN) begin
			r.value = known_val;
			r.last = known_last;
			pending_laplacians.push_back(r);
		end else if (kind == STEP_CHECKED && gives) begin
			pending_laplacians.push_back(r);
		end
	endtask

	task automatic run_volume();
		int unsigned mode, w_cfg, h_cfg, d_cfg, w, h, d, plane, total, cut, k, reps;
		mode = $urandom_range(0, 9);
		w_cfg = $urandom_range(0, 5);
		h_cfg = $urandom_range(0, 5);
		d_cfg = $urandom_range(0, 4);
		case (mode)
			0: begin
				w_cfg = $urandom_range(64, 127);
				h_cfg = 1;
				d_cfg = $urandom_range(1, 2);
			end
			1: begin
				w_cfg = 1;
				h_cfg = $urandom_range(64, 127);
				d_cfg = $urandom_range(1, 2);
			end
			2: begin
				w_cfg = $urandom_range(1, 2);
				h_cfg = 1;
				d_cfg = $urandom_range(0, 1) ? 2047 : $urandom_range(0, 2047);
			end
			default: ;
		endcase
		write_reg(REG_WIDTH, 11'(w_cfg | ($urandom_range(0, 15) << 7)));
		write_reg(REG_HEIGHT, 11'(h_cfg | ($urandom_range(0, 15) << 7)));
		write_reg(REG_DEPTH, 11'(d_cfg));
		if ($urandom_range(0, 7) == 0)
			write_reg(REG_SPARE, 11'($urandom));
		volume_shape(w, h, d, plane, total);
		calm = ($urandom_range(0, 3) == 0);
		reps = (total <= 60) ? $urandom_range(1, 2) : 1;
		repeat (reps) begin
			cut = total;
			if (total > 200 || $urandom_range(0, 5) == 0)
				cut = $urandom_range(1, (total < 60) ? total : 60);
			for (k = 0; k < cut; k++) begin
				// early drain, dropped by the block
				if ($urandom_range(0, 11) == 0)
					issue(ACT_DRAIN, rand_voxel(), STEP_CHECKED, '0, 1'b0);
				issue(ACT_PUSH, rand_voxel(), STEP_CHECKED, '0, 1'b0);
			end
			if (cut == total) begin
				if ($urandom_range(0, 2) == 0)
					issue(ACT_PUSH, rand_voxel(), STEP_CHECKED, '0, 1'b0);
				for (k = 0; k < plane; k++)
					issue(ACT_DRAIN, rand_voxel(), STEP_CHECKED, '0, 1'b0);
				if ($urandom_range(0, 3) == 0)
					issue(ACT_DRAIN, rand_voxel(), STEP_CHECKED, '0, 1'b0);
			end
		end
	endtask

	initial begin : result_side
		int n;
		bit held_long;
		held_long = 1'b0;
		res_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!held_long && results_seen >= 40 && item_valid) begin
				// long back-pressure so the input side fills up
				held_long = 1'b1;
				res_stall <= 1'b1;
				for (n = 0; n < LONG_HOLD; n++)
					@(posedge clk);
				res_stall <= 1'b0;
			end else if (!quiet && !calm && $urandom_range(0, 5) == 0) begin
				res_stall <= 1'b1;
				repeat ($urandom_range(1, 5)) @(posedge clk);
				res_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : result_check
		lap_result_t want;
		bit orphan;
		if (arst_n && res_valid && !res_stall) begin
			results_seen++;
			orphan = (pending_laplacians.size() == 0);
			want = '0;
			if (!orphan)
				want = pending_laplacians.pop_front();
			if (orphan || result_value !== want.value || is_last !== want.last) begin
				if (mismatches < 10)
					$display("%0t: result mismatch%s: expected %0d last %0b, got %0d last %0b",
						$time, orphan ? " (nothing pending)" : "", $signed(want.value),
						want.last, $signed(result_value), is_last);
				mismatches++;
			end
		end
	end

	initial begin
		#2000000;
		$display("== FAIL ==");
		$finish;
	end

	initial begin : stimulus
		arst_n <= 1'b0;
		item_valid <= 1'b0;
		action <= ACT_PUSH;
		sample <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_WIDTH;
		cfg_data <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int i = 0; i < PLAN_LEN; i++) begin
			if (PLAN[i].kind == STEP_REG)
				write_reg(PLAN[i].idx, PLAN[i].data);
			else
				issue(PLAN[i].act, PLAN[i].smp, PLAN[i].kind, PLAN[i].value, PLAN[i].last);
		end
		while (reqs_effective < REQ_GOAL)
			run_volume();
		settle();
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/lap3d_pkg.sv
rtl/core/lap3d_front.sv
rtl/core/lap3d_fifo.sv
rtl/core/lap3d_delay.sv
rtl/core/lap3d_back.sv
rtl/core/laplacian_3d_stencil.sv
verif/tb.sv
